// ----- rtl/core/sabs_pkg.sv -----
// ----------------------------------------------------------------------------
// sabs_pkg
// Shared types and constants of the suffix array binary search block.
// ----------------------------------------------------------------------------
package sabs_pkg;

  localparam int unsigned TEXT_DEPTH_DEF  = 4096;
  localparam int unsigned TABLE_DEPTH_DEF = 1024;
  localparam int unsigned QUERY_DEPTH_DEF = 64;

  localparam int unsigned KIND_W   = 2;
  localparam int unsigned TADDR_W  = 12;
  localparam int unsigned SLOT_W   = 10;
  localparam int unsigned OFFSET_W = 12;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned INDEX_W  = 10;

  localparam int unsigned TLEN_REG_W  = 13;
  localparam int unsigned COUNT_REG_W = 11;
  localparam int unsigned CFG_IDX_W   = 8;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_LENGTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SUFFIX_COUNT = 8'd1;

  localparam logic [TLEN_REG_W-1:0]  TLEN_RESET  = 13'd4096;
  localparam logic [COUNT_REG_W-1:0] COUNT_RESET = 11'd1024;

  // Wide enough for the largest supported query buffer.
  localparam int unsigned QLEN_W = 11;

  typedef enum logic [KIND_W-1:0] {
    KIND_TEXT  = 2'd0,
    KIND_TABLE = 2'd1,
    KIND_QUERY = 2'd2
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_FOUND     = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_TOO_LONG  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_TREAD,
    S_CMP,
    S_CWAIT,
    S_DONE
  } back_state_e;

  typedef struct packed {
    logic [QLEN_W-1:0] qlen;
    logic              overflow;
  } cmd_t;

endpackage

// ----- rtl/core/sabs_if.sv -----
// ----------------------------------------------------------------------------
// sabs_if
// Valid/ready channels of the suffix array binary search block.
// ----------------------------------------------------------------------------
interface sabs_in_if;
  import sabs_pkg::*;
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [TADDR_W-1:0]  text_address;
  logic [SLOT_W-1:0]   slot;
  logic [OFFSET_W-1:0] start_offset;
  logic [BYTE_W-1:0]   byte_value;
  logic                last;
  modport source (output valid, kind, text_address, slot, start_offset, byte_value, last,
                  input ready);
  modport sink (input valid, kind, text_address, slot, start_offset, byte_value, last,
                output ready);
endinterface

interface sabs_out_if;
  import sabs_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [INDEX_W-1:0]  index;
  modport source (output valid, status, index, input ready);
  modport sink (input valid, status, index, output ready);
endinterface

interface sabs_cfg_if;
  import sabs_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/suffix_array_lcp_binary_search.sv -----
// ----------------------------------------------------------------------------
// suffix_array_lcp_binary_search
// Substring search over a loaded text through a sorted suffix table.
// ----------------------------------------------------------------------------
// Text bytes, suffix table entries and query bytes are taken one per cycle
// while no search is queued or running. The final query byte starts a binary
// search; from that transfer until the search result sits in the output
// register, in_i.ready stays low. Each midpoint takes a window check and a
// table read; each compared query byte takes one registered read of the text
// and query RAMs, then the compare; a further compare step ends a compare
// that runs through the whole query or reaches the end of the text. At most
// about log2(suffix_count)+1 midpoints occur. The idle state takes the command
// from the queue, a final window check ends a search that finds nothing, and
// the done state moves the result into the output register. An overlong query
// goes from the queue straight to the done state. Text and table stores are
// undefined until written; no clearing pass is run.
module suffix_array_lcp_binary_search
  import sabs_pkg::*;
#(
  parameter int unsigned TEXT_DEPTH  = TEXT_DEPTH_DEF,
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int unsigned QUERY_DEPTH = QUERY_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sabs_in_if.sink     in_i,
  sabs_cfg_if.sink    cfg_i,
  sabs_out_if.source  out_o
);

  localparam int unsigned TextAw  = $clog2(TEXT_DEPTH);
  localparam int unsigned TableAw = $clog2(TABLE_DEPTH);
  localparam int unsigned QueryAw = $clog2(QUERY_DEPTH);

  logic [TLEN_REG_W-1:0]  text_length_q;
  logic [COUNT_REG_W-1:0] suffix_count_q;

  logic                push, pop, fifo_empty, fifo_full, back_busy;
  cmd_t                cmd_in, cmd_out;
  logic                text_we, table_we, query_we;
  logic [TextAw-1:0]   text_waddr, text_raddr;
  logic [TableAw-1:0]  table_waddr, table_raddr;
  logic [QueryAw-1:0]  query_waddr, query_raddr;
  logic [BYTE_W-1:0]   text_wdata, text_rdata, query_wdata, query_rdata;
  logic [OFFSET_W-1:0] table_wdata, table_rdata;
  logic                unused_full;

  assign cfg_i.ready = 1'b1;
  assign unused_full = fifo_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_length_q  <= TLEN_RESET;
      suffix_count_q <= COUNT_RESET;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == CFG_TEXT_LENGTH) begin
        text_length_q <= cfg_i.data[TLEN_REG_W-1:0];
      end else if (cfg_i.index == CFG_SUFFIX_COUNT) begin
        suffix_count_q <= cfg_i.data[COUNT_REG_W-1:0];
      end
    end
  end

  sabs_front #(
    .TEXT_DEPTH (TEXT_DEPTH),
    .TABLE_DEPTH(TABLE_DEPTH),
    .QUERY_DEPTH(QUERY_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .back_busy_i  (back_busy),
    .fifo_empty_i (fifo_empty),
    .push_o       (push),
    .cmd_o        (cmd_in),
    .text_we_o    (text_we),
    .text_waddr_o (text_waddr),
    .text_wdata_o (text_wdata),
    .table_we_o   (table_we),
    .table_waddr_o(table_waddr),
    .table_wdata_o(table_wdata),
    .query_we_o   (query_we),
    .query_waddr_o(query_waddr),
    .query_wdata_o(query_wdata)
  );

  sabs_fifo #(
    .Depth(2),
    .T    (cmd_t)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (cmd_in),
    .pop_i  (pop),
    .data_o (cmd_out),
    .empty_o(fifo_empty),
    .full_o (fifo_full)
  );

  sabs_ram #(.Width(BYTE_W), .Depth(TEXT_DEPTH)) u_text_ram (
    .clk_i  (clk_i),
    .we_i   (text_we),
    .waddr_i(text_waddr),
    .wdata_i(text_wdata),
    .raddr_i(text_raddr),
    .rdata_o(text_rdata)
  );

  sabs_ram #(.Width(OFFSET_W), .Depth(TABLE_DEPTH)) u_table_ram (
    .clk_i  (clk_i),
    .we_i   (table_we),
    .waddr_i(table_waddr),
    .wdata_i(table_wdata),
    .raddr_i(table_raddr),
    .rdata_o(table_rdata)
  );

  sabs_ram #(.Width(BYTE_W), .Depth(QUERY_DEPTH)) u_query_ram (
    .clk_i  (clk_i),
    .we_i   (query_we),
    .waddr_i(query_waddr),
    .wdata_i(query_wdata),
    .raddr_i(query_raddr),
    .rdata_o(query_rdata)
  );

  sabs_back #(
    .TEXT_DEPTH (TEXT_DEPTH),
    .TABLE_DEPTH(TABLE_DEPTH),
    .QUERY_DEPTH(QUERY_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .text_length_i (text_length_q),
    .suffix_count_i(suffix_count_q),
    .fifo_empty_i  (fifo_empty),
    .cmd_i         (cmd_out),
    .pop_o         (pop),
    .busy_o        (back_busy),
    .table_raddr_o (table_raddr),
    .table_rdata_i (table_rdata),
    .text_raddr_o  (text_raddr),
    .text_rdata_i  (text_rdata),
    .query_raddr_o (query_raddr),
    .query_rdata_i (query_rdata),
    .out_o         (out_o)
  );

  // The queue holds at most one search, since the front end waits for it.
  a_queue_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !unused_full)
    else $error("search queue overfilled");

  a_ready_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!fifo_empty || back_busy) |-> !in_i.ready)
    else $error("item accepted during search");

  a_push_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (fifo_empty && !back_busy))
    else $error("search queued while another is pending");

endmodule

// ----- rtl/core/sabs_ram.sv -----
// ----------------------------------------------------------------------------
// sabs_ram
// Generic RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module sabs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned Aw = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/sabs_fifo.sv -----
// ----------------------------------------------------------------------------
// sabs_fifo
// Short command queue between the load front end and the search engine.
// ----------------------------------------------------------------------------
module sabs_fifo #(
  parameter int unsigned Depth = 2,
  parameter type T = logic,
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o,
  output logic full_o
);

  T                  mem_q [Depth];
  logic [Aw-1:0]     wptr_q, wptr_d, rptr_q, rptr_d;
  logic [Aw:0]       cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (Aw+1)'(Depth));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == Aw'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == Aw'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

// ----- rtl/core/sabs_front.sv -----
// ----------------------------------------------------------------------------
// sabs_front
// Accepts load and query items, writes the stores and queues searches.
// ----------------------------------------------------------------------------
module sabs_front
  import sabs_pkg::*;
#(
  parameter int unsigned TEXT_DEPTH  = TEXT_DEPTH_DEF,
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int unsigned QUERY_DEPTH = QUERY_DEPTH_DEF,
  localparam int unsigned TextAw  = $clog2(TEXT_DEPTH),
  localparam int unsigned TableAw = $clog2(TABLE_DEPTH),
  localparam int unsigned QueryAw = $clog2(QUERY_DEPTH),
  localparam int unsigned Qlw     = $clog2(QUERY_DEPTH + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  sabs_in_if.sink             in_i,
  input  logic                back_busy_i,
  input  logic                fifo_empty_i,
  output logic                push_o,
  output cmd_t                cmd_o,
  output logic                text_we_o,
  output logic [TextAw-1:0]   text_waddr_o,
  output logic [BYTE_W-1:0]   text_wdata_o,
  output logic                table_we_o,
  output logic [TableAw-1:0]  table_waddr_o,
  output logic [OFFSET_W-1:0] table_wdata_o,
  output logic                query_we_o,
  output logic [QueryAw-1:0]  query_waddr_o,
  output logic [BYTE_W-1:0]   query_wdata_o
);

  logic           accept;
  logic [Qlw-1:0] qlen_q, qlen_d;
  logic           ovf_q, ovf_d;
  logic           room;

  // New items wait while a search is queued or running, so the query
  // buffer and the stores never change under the search engine.
  assign in_i.ready = fifo_empty_i && !back_busy_i;
  assign accept     = in_i.valid && in_i.ready;
  assign room       = (32'(qlen_q) < QUERY_DEPTH);

  assign text_waddr_o  = TextAw'(in_i.text_address);
  assign text_wdata_o  = in_i.byte_value;
  assign table_waddr_o = TableAw'(in_i.slot);
  assign table_wdata_o = in_i.start_offset;
  assign query_waddr_o = QueryAw'(qlen_q);
  assign query_wdata_o = in_i.byte_value;

  always_comb begin
    text_we_o  = 1'b0;
    table_we_o = 1'b0;
    query_we_o = 1'b0;
    push_o     = 1'b0;
    qlen_d     = qlen_q;
    ovf_d      = ovf_q;
    cmd_o.qlen = '0;
    cmd_o.overflow = 1'b0;
    if (accept) begin
      case (in_i.kind)
        KIND_TEXT: begin
          text_we_o = (32'(in_i.text_address) < TEXT_DEPTH);
        end
        KIND_TABLE: begin
          table_we_o = (32'(in_i.slot) < TABLE_DEPTH);
        end
        KIND_QUERY: begin
          if (room) begin
            query_we_o = 1'b1;
            qlen_d     = qlen_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          if (in_i.last) begin
            push_o         = 1'b1;
            cmd_o.qlen     = QLEN_W'(qlen_d);
            cmd_o.overflow = ovf_d;
            qlen_d         = '0;
            ovf_d          = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qlen_q <= '0;
      ovf_q  <= 1'b0;
    end else begin
      qlen_q <= qlen_d;
      ovf_q  <= ovf_d;
    end
  end

endmodule

// ----- rtl/core/sabs_back.sv -----
// ----------------------------------------------------------------------------
// sabs_back
// Search engine: binary search over the suffix table with byte compares.
// ----------------------------------------------------------------------------
module sabs_back
  import sabs_pkg::*;
#(
  parameter int unsigned TEXT_DEPTH  = TEXT_DEPTH_DEF,
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int unsigned QUERY_DEPTH = QUERY_DEPTH_DEF,
  localparam int unsigned TextAw  = $clog2(TEXT_DEPTH),
  localparam int unsigned TableAw = $clog2(TABLE_DEPTH),
  localparam int unsigned QueryAw = $clog2(QUERY_DEPTH),
  localparam int unsigned Qlw     = $clog2(QUERY_DEPTH + 1),
  localparam int unsigned Mw      = $clog2(TABLE_DEPTH + 1),
  localparam int unsigned Lw      = $clog2(TEXT_DEPTH + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [TLEN_REG_W-1:0]  text_length_i,
  input  logic [COUNT_REG_W-1:0] suffix_count_i,
  input  logic                   fifo_empty_i,
  input  cmd_t                   cmd_i,
  output logic                   pop_o,
  output logic                   busy_o,
  output logic [TableAw-1:0]     table_raddr_o,
  input  logic [OFFSET_W-1:0]    table_rdata_i,
  output logic [TextAw-1:0]      text_raddr_o,
  input  logic [BYTE_W-1:0]      text_rdata_i,
  output logic [QueryAw-1:0]     query_raddr_o,
  input  logic [BYTE_W-1:0]      query_rdata_i,
  sabs_out_if.source             out_o
);

  back_state_e         state_q, state_d;
  logic [Mw-1:0]       left_q, left_d, right_q, right_d, mid_q, mid_d, count_q, count_d;
  logic [Lw-1:0]       tlen_q, tlen_d;
  logic [OFFSET_W-1:0] start_q, start_d;
  logic [Qlw-1:0]      i_q, i_d, qlen_q, qlen_d;
  logic                res_valid_q, res_valid_d;
  status_e             res_status_q, res_status_d;
  logic [INDEX_W-1:0]  res_index_q, res_index_d;
  status_e             fin_status_q, fin_status_d;
  logic [INDEX_W-1:0]  fin_index_q, fin_index_d;
  logic [Mw-1:0]       mid_c;
  logic [31:0]         pos;

  assign mid_c = left_q + ((right_q - left_q) >> 1);
  assign pos   = 32'(start_q) + 32'(i_q);

  assign busy_o        = (state_q != S_IDLE);
  assign table_raddr_o = TableAw'(mid_c);
  assign text_raddr_o  = TextAw'(pos);
  assign query_raddr_o = QueryAw'(i_q);

  assign out_o.valid  = res_valid_q;
  assign out_o.status = res_status_q;
  assign out_o.index  = res_index_q;

  always_comb begin
    state_d      = state_q;
    left_d       = left_q;
    right_d      = right_q;
    mid_d        = mid_q;
    count_d      = count_q;
    tlen_d       = tlen_q;
    start_d      = start_q;
    i_d          = i_q;
    qlen_d       = qlen_q;
    fin_status_d = fin_status_q;
    fin_index_d  = fin_index_q;
    res_valid_d  = res_valid_q && !out_o.ready;
    res_status_d = res_status_q;
    res_index_d  = res_index_q;
    pop_o        = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (!fifo_empty_i) begin
          pop_o   = 1'b1;
          qlen_d  = Qlw'(cmd_i.qlen);
          tlen_d  = Lw'((32'(text_length_i) > TEXT_DEPTH) ? TEXT_DEPTH
                                                          : 32'(text_length_i));
          count_d = Mw'((32'(suffix_count_i) > TABLE_DEPTH) ? TABLE_DEPTH
                                                            : 32'(suffix_count_i));
          left_d  = '0;
          right_d = count_d;
          fin_index_d = '0;
          if (cmd_i.overflow) begin
            fin_status_d = STATUS_TOO_LONG;
            state_d      = S_DONE;
          end else begin
            state_d = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (left_q < right_q) begin
          mid_d   = mid_c;
          state_d = S_TREAD;
        end else begin
          fin_status_d = STATUS_NOT_FOUND;
          state_d      = S_DONE;
        end
      end
      S_TREAD: begin
        start_d = table_rdata_i;
        i_d     = '0;
        state_d = S_CMP;
      end
      S_CMP: begin
        if (i_q == qlen_q) begin
          fin_status_d = STATUS_FOUND;
          fin_index_d  = INDEX_W'(mid_q);
          state_d      = S_DONE;
        end else if (pos >= 32'(tlen_q)) begin
          left_d  = mid_q + 1'b1;
          state_d = S_CHECK;
        end else begin
          state_d = S_CWAIT;
        end
      end
      S_CWAIT: begin
        if (text_rdata_i < query_rdata_i) begin
          left_d  = mid_q + 1'b1;
          state_d = S_CHECK;
        end else if (text_rdata_i > query_rdata_i) begin
          right_d = mid_q;
          state_d = S_CHECK;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = S_CMP;
        end
      end
      S_DONE: begin
        if (!res_valid_q || out_o.ready) begin
          res_valid_d  = 1'b1;
          res_status_d = fin_status_q;
          res_index_d  = fin_index_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    left_q       <= left_d;
    right_q      <= right_d;
    mid_q        <= mid_d;
    count_q      <= count_d;
    tlen_q       <= tlen_d;
    start_q      <= start_d;
    i_q          <= i_d;
    qlen_q       <= qlen_d;
    fin_status_q <= fin_status_d;
    fin_index_q  <= fin_index_d;
    res_status_q <= res_status_d;
    res_index_q  <= res_index_d;
  end

  // The search window never inverts and never grows past the table.
  a_window_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK) |-> (left_q <= right_q))
    else $error("search window inverted");

  a_window_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK) |-> (right_q <= count_q))
    else $error("search window beyond table");

  a_cmp_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CWAIT) |-> (i_q < qlen_q))
    else $error("compare past end of query");

  a_mid_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TREAD) |-> (mid_q >= left_q && mid_q < right_q))
    else $error("midpoint outside window");

endmodule
